@@ hw/rtl/swrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sample window ring capture: shared definitions
// Commands, internal operation codes, register indexes, queue depths and the
// structures that pass between the front end, the back end and the result
// queue.
// ----------------------------------------------------------------------------
package swrc_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 32;
  localparam int unsigned FQ_DEPTH         = 2;
  localparam int unsigned OQ_DEPTH         = 4;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_POLL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic CFG_STALE_LIMIT = 1'b0;
  localparam logic CFG_POLL_PERIOD = 1'b1;

  localparam logic [15:0] STALE_LIMIT_RST = 16'd1000;
  localparam logic [9:0]  POLL_PERIOD_RST = 10'd4;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_POLL = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] sample;
    logic        ok;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic        last;
    logic        healthy;
    logic        stored;
    logic [31:0] total;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/sample_window_ring_capture_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sample window ring capture: top level
// A tick or poll gives a status result, registered in the back end and then
// queued; ticks and polls sustain one per cycle while the result queue has
// room. A window read has a set-up step and then gives WindowDepth results,
// one ring entry per cycle while the result queue has room, through the
// single ring read port. Reset clears counters, health and queues and
// restores register defaults; ring contents stay undefined, never cleared.
// ----------------------------------------------------------------------------
module sample_window_ring_capture_top
  import swrc_pkg::*;
#(
  parameter int unsigned WindowDepth = WINDOW_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [15:0] raw_sample_i,
  input  wire logic        read_ok_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind_o,
  output logic [15:0]      window_sample_o,
  output logic             last_o,
  output logic             healthy_o,
  output logic             stored_o,
  output logic [31:0]      total_count_o
);

  localparam int unsigned OqCntW = $clog2(OQ_DEPTH + 1);

  logic              item_vld, item_pop, res_push;
  item_t             item;
  result_t           res, head;
  logic [OqCntW-1:0] oq_count;

  swrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (cmd_i),
    .raw_sample_i(raw_sample_i),
    .read_ok_i   (read_ok_i),
    .full_o      (full),
    .item_vld_o  (item_vld),
    .item_o      (item),
    .item_pop_i  (item_pop)
  );

  swrc_back #(
    .WindowDepth(WindowDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_vld_i (item_vld),
    .item_i     (item),
    .item_pop_o (item_pop),
    .oq_count_i (oq_count),
    .res_push_o (res_push),
    .res_o      (res)
  );

  swrc_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head),
    .count_o(oq_count)
  );

  assign kind_o          = head.kind;
  assign window_sample_o = head.sample;
  assign last_o          = head.last;
  assign healthy_o       = head.healthy;
  assign stored_o        = head.stored;
  assign total_count_o   = head.total;

endmodule
`default_nettype wire

@@ hw/rtl/swrc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swrc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/swrc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sample window ring capture: front end
// Accepts input transfers, decodes the command into an operation and holds
// the items in a short queue for the back end.
// ----------------------------------------------------------------------------
module swrc_front
  import swrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [15:0] raw_sample_i,
  input  wire logic        read_ok_i,
  output logic             full_o,
  output logic             item_vld_o,
  output item_t            item_o,
  input  wire logic        item_pop_i
);

  localparam int unsigned PtrW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FQ_DEPTH + 1);

  item_t            buf_q [FQ_DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr, rd;
  item_t            item_in;

  always_comb begin
    item_in.sample = raw_sample_i;
    item_in.ok     = read_ok_i;
    case (cmd_i)
      CMD_TICK: item_in.op = OP_TICK;
      CMD_POLL: item_in.op = OP_POLL;
      CMD_READ: item_in.op = OP_READ;
      default:  item_in.op = OP_NOP;
    endcase
  end

  assign full_o     = (cnt_q == CntW'(FQ_DEPTH));
  assign item_vld_o = (cnt_q != '0);
  assign item_o     = buf_q[rptr_q];
  assign wr         = push_i && !full_o;
  assign rd         = item_pop_i && item_vld_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = (wptr_q == PtrW'(FQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd) begin
      rptr_d = (rptr_q == PtrW'(FQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wptr_q] <= item_in;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/swrc_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sample window ring capture: result queue
// Holds finished results until the consumer takes them, oldest first.
// ----------------------------------------------------------------------------
module swrc_outq
  import swrc_pkg::*;
#(
  localparam int unsigned CntW = $clog2(OQ_DEPTH + 1)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  result_t         data_i,
  input  wire logic       pop_i,
  output logic            empty_o,
  output result_t         head_o,
  output logic [CntW-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(OQ_DEPTH);

  result_t          buf_q [OQ_DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rd;

  assign empty_o = (cnt_q == '0);
  assign head_o  = buf_q[rptr_q];
  assign count_o = cnt_q;
  assign rd      = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/swrc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sample window ring capture: back end
// Keeps the age counters, health flag and sample count, writes polled
// samples into the ring and walks the ring for a window read.
// ----------------------------------------------------------------------------
module swrc_back
  import swrc_pkg::*;
#(
  parameter int unsigned WindowDepth = WINDOW_DEPTH_DEF,
  localparam int unsigned OqCntW = $clog2(OQ_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              item_vld_i,
  input  item_t                  item_i,
  output logic                   item_pop_o,
  input  wire logic [OqCntW-1:0] oq_count_i,
  output logic                   res_push_o,
  output result_t                res_o
);

  localparam int unsigned IdxW  = $clog2(WindowDepth);
  localparam int unsigned FillW = $clog2(WindowDepth + 1);

  logic [15:0]      stale_lim_q;
  logic [9:0]       period_q;
  logic [15:0]      ms_fill_q, ms_fill_d;
  logic [15:0]      ms_poll_q, ms_poll_d;
  logic [31:0]      total_q, total_d;
  logic             health_q, health_d;
  logic [IdxW-1:0]  wslot_q, wslot_d;
  logic [FillW-1:0] fill_q, fill_d;
  state_e           state_q, state_d;
  logic [IdxW-1:0]  rslot_q, rslot_d;
  logic [IdxW-1:0]  rcnt_q, rcnt_d;
  logic             win_ok_q, win_ok_d;
  logic             pipe_vld_q;
  logic             pipe_ram_q, pipe_ram_d;
  result_t          pipe_q, res;
  logic             space, issue, ram_we, ram_re, stored, win_ok;
  logic [15:0]      ram_rdata;

  assign space = (oq_count_i + OqCntW'(pipe_vld_q)) < OqCntW'(OQ_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_lim_q <= STALE_LIMIT_RST;
      period_q    <= POLL_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STALE_LIMIT: stale_lim_q <= cfg_wdata_i;
        CFG_POLL_PERIOD: period_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ms_fill_d  = ms_fill_q;
    ms_poll_d  = ms_poll_q;
    total_d    = total_q;
    health_d   = health_q;
    wslot_d    = wslot_q;
    fill_d     = fill_q;
    state_d    = state_q;
    rslot_d    = rslot_q;
    rcnt_d     = rcnt_q;
    win_ok_d   = win_ok_q;
    item_pop_o = 1'b0;
    issue      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    stored     = 1'b0;
    win_ok     = 1'b0;
    pipe_ram_d = 1'b0;
    res        = '0;
    case (state_q)
      ST_IDLE: begin
        if (item_vld_i && space) begin
          item_pop_o = 1'b1;
          issue      = 1'b1;
          case (item_i.op)
            OP_TICK: begin
              if (ms_fill_q != '1) begin
                ms_fill_d = ms_fill_q + 1'b1;
              end
              if (ms_poll_q != '1) begin
                ms_poll_d = ms_poll_q + 1'b1;
              end
              if (health_q && (ms_fill_d > stale_lim_q)) begin
                health_d = 1'b0;
              end
            end
            OP_POLL: begin
              if (health_q && (ms_fill_q > stale_lim_q)) begin
                health_d = 1'b0;
              end
              if (ms_poll_q >= {6'd0, period_q}) begin
                ms_poll_d = '0;
                if (item_i.ok) begin
                  ram_we    = 1'b1;
                  wslot_d   = (wslot_q == IdxW'(WindowDepth - 1)) ? '0 : wslot_q + 1'b1;
                  if (fill_q != FillW'(WindowDepth)) begin
                    fill_d = fill_q + 1'b1;
                  end
                  total_d   = total_q + 32'd1;
                  ms_fill_d = '0;
                  health_d  = 1'b1;
                  stored    = 1'b1;
                end
              end
            end
            OP_READ: begin
              issue  = 1'b0;
              win_ok = (fill_q == FillW'(WindowDepth)) && !(ms_fill_q > stale_lim_q)
                       && health_q;
              if (!win_ok) begin
                health_d = 1'b0;
              end
              win_ok_d = win_ok;
              rslot_d  = wslot_q;
              rcnt_d   = '0;
              state_d  = ST_WALK;
            end
            default: ;
          endcase
          res.kind    = KIND_STATUS;
          res.last    = 1'b1;
          res.healthy = health_d;
          res.stored  = stored;
          res.total   = total_d;
        end
      end
      ST_WALK: begin
        if (space) begin
          issue       = 1'b1;
          ram_re      = win_ok_q;
          pipe_ram_d  = win_ok_q;
          res.kind    = KIND_WINDOW;
          res.last    = (rcnt_q == IdxW'(WindowDepth - 1));
          res.healthy = health_q;
          res.total   = total_q;
          rslot_d     = (rslot_q == IdxW'(WindowDepth - 1)) ? '0 : rslot_q + 1'b1;
          rcnt_d      = rcnt_q + 1'b1;
          if (res.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_fill_q  <= '0;
      ms_poll_q  <= '0;
      total_q    <= '0;
      health_q   <= 1'b0;
      wslot_q    <= '0;
      fill_q     <= '0;
      state_q    <= ST_IDLE;
      rslot_q    <= '0;
      rcnt_q     <= '0;
      win_ok_q   <= 1'b0;
      pipe_vld_q <= 1'b0;
    end else begin
      ms_fill_q  <= ms_fill_d;
      ms_poll_q  <= ms_poll_d;
      total_q    <= total_d;
      health_q   <= health_d;
      wslot_q    <= wslot_d;
      fill_q     <= fill_d;
      state_q    <= state_d;
      rslot_q    <= rslot_d;
      rcnt_q     <= rcnt_d;
      win_ok_q   <= win_ok_d;
      pipe_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pipe_q     <= res;
      pipe_ram_q <= pipe_ram_d;
    end
  end

  swrc_ram #(
    .Width(16),
    .Depth(WindowDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wslot_q),
    .wdata_i(item_i.sample),
    .re_i   (ram_re),
    .raddr_i(rslot_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    res_o        = pipe_q;
    res_o.sample = pipe_ram_q ? ram_rdata : 16'd0;
  end

  assign res_push_o = pipe_vld_q;

endmodule
`default_nettype wire
